// ===== rtl/lecpg_pkg.sv =====
// Shared constants, types and the arctangent table for the line end cap path generator.
`default_nettype none

package lecpg_pkg;

  localparam logic [3:0] STYLE_NONE            = 4'd0;
  localparam logic [3:0] STYLE_OPEN_ROUND      = 4'd1;
  localparam logic [3:0] STYLE_CLOSED_ROUND    = 4'd2;
  localparam logic [3:0] STYLE_OPEN_ARROW      = 4'd3;
  localparam logic [3:0] STYLE_CLOSED_ARROW    = 4'd4;
  localparam logic [3:0] STYLE_OPEN_SQUARE     = 4'd5;
  localparam logic [3:0] STYLE_CLOSED_SQUARE   = 4'd6;
  localparam logic [3:0] STYLE_OPEN_TRIANGLE   = 4'd7;
  localparam logic [3:0] STYLE_CLOSED_TRIANGLE = 4'd8;

  localparam logic [2:0] CMD_MOVE   = 3'd0;
  localparam logic [2:0] CMD_LINE   = 3'd1;
  localparam logic [2:0] CMD_CIRCLE = 3'd2;
  localparam logic [2:0] CMD_FILL   = 3'd3;
  localparam logic [2:0] CMD_STROKE = 3'd4;
  localparam logic [2:0] CMD_ERROR  = 3'd5;

  // Datapath widths: vectoring CORDIC, angles (Q5.30), rotation CORDIC, scaled offsets.
  localparam int VEC_W = 37;
  localparam int ANG_W = 35;
  localparam int ROT_W = 33;
  localparam int OFF_W = 37;

  localparam logic [30:0] SEC_Q30 = 31'd1088525795;
  localparam logic signed [ANG_W-1:0] HALF_ANGLE_Q30 = 35'sd177167401;
  localparam logic signed [ANG_W-1:0] PI_Q30         = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALFPI_Q30     = 35'sd1686629713;
  localparam logic signed [ROT_W-1:0] INVGAIN_Q30    = 33'sd652032874;

  localparam logic signed [ANG_W-1:0] ATAN_HEAD [10] = '{
    35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158, 35'sd67021686,
    35'sd33543515,  35'sd16775850,  35'sd8388437,   35'sd4194282,   35'sd2097149
  };

  // Micro-rotation angle of CORDIC step i in Q5.30.
  function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned i);
    logic signed [ANG_W-1:0] r;
    if (i < 10) begin
      r = ATAN_HEAD[i[3:0]];
    end else if (i <= 29) begin
      r = $signed((ANG_W'(1) << (30 - i)) - ANG_W'(1));
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // Per-item values that ride along the pipeline.
  typedef struct packed {
    logic [3:0]         style;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic [31:0]        side;
    logic [30:0]        rad;
    logic               zero;
  } sb_t;

endpackage

`default_nettype wire

// ===== rtl/line_end_cap_path_generator_top.sv =====
// Top level of the line end cap path generator: CORDIC pipeline and command serializer.
`default_nettype none

// A segment and a cap style go in; the path commands that draw the cap come out one beat
// at a time on the result port. A new item can enter every cycle in which in_stall is low;
// the pipeline runs 2*CORDIC_STAGES+11 register stages (vectoring CORDIC for the direction,
// three rotation CORDICs for the corners, multiply, round, saturate) and then the serializer.
// The single result port sets the sustained pace: the serializer holds a cap until all of
// its beats are out (one or two for round caps, up to seven for a closed square), and the
// pipeline stalls behind it; a cap of style none produces no beats.
module line_end_cap_path_generator_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         cap_style,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic [30:0]        cap_size,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         command,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [30:0]        radius,
  output logic               last
);
  import lecpg_pkg::*;

  localparam int N          = CORDIC_STAGES;
  localparam int ST_VEC_END = 4 + N;
  localparam int ST_NEG     = 7 + 2 * N;
  localparam int ST_OFF     = 9 + 2 * N;
  localparam int ST_PNT     = 10 + 2 * N;
  localparam int DEPTH      = 11 + 2 * N;

  localparam logic [2:0] SEL_ZERO = 3'd0;
  localparam logic [2:0] SEL_END  = 3'd1;
  localparam logic [2:0] SEL_P1   = 3'd2;
  localparam logic [2:0] SEL_P2   = 3'd3;
  localparam logic [2:0] SEL_P3   = 3'd4;

  localparam logic [2:0] CLS_ERROR  = 3'd0;
  localparam logic [2:0] CLS_ROUND  = 3'd1;
  localparam logic [2:0] CLS_ARROW  = 3'd2;
  localparam logic [2:0] CLS_SQUARE = 3'd3;
  localparam logic [2:0] CLS_TRI    = 3'd4;

  logic             en;
  logic             take;
  logic             ld;
  logic [DEPTH-1:0] vld;
  sb_t              sb [1:DEPTH-1];

  // Stage 0: differences and size product.
  logic [3:0]         s0_style;
  logic signed [31:0] s0_ex, s0_ey;
  logic signed [32:0] s0_dx, s0_dy;
  logic [61:0]        s0_prod;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_style <= cap_style;
      s0_ex    <= end_x;
      s0_ey    <= end_y;
      s0_dx    <= {end_x[31], end_x} - {start_x[31], start_x};
      s0_dy    <= {end_y[31], end_y} - {start_y[31], start_y};
      s0_prod  <= 62'(cap_size) * 62'(SEC_Q30);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Stage 1: rounding of side and radius, larger absolute component of the direction vector.
  logic [61:0]        prod_side, prod_rad;
  logic [32:0]        ax, ay;
  logic [32:0]        s1_m;
  logic signed [33:0] s1_x, s1_y;

  assign prod_side = s0_prod + (62'd1 << 29);
  assign prod_rad  = s0_prod + (62'd1 << 30);
  assign ax = s0_dx[32] ? 33'(-s0_dx) : 33'(s0_dx);
  assign ay = s0_dy[32] ? 33'(-s0_dy) : 33'(s0_dy);

  always_ff @(posedge clk) begin
    if (en) begin
      sb[1] <= '{style: s0_style, ex: s0_ex, ey: s0_ey, side: prod_side[61:30],
                 rad: prod_rad[61:31], zero: (s0_dx == '0) && (s0_dy == '0)};
      s1_m  <= (ax > ay) ? ax : ay;
      s1_x  <= {s0_dx[32], s0_dx};
      s1_y  <= {s0_dy[32], s0_dy};
    end
  end

  // Stages 2 and 3: scale the vector up until its larger component reaches 2^32,
  // by a binary search over shift amounts 32, 16, 8 and then 4, 2, 1.
  logic [32:0]        na_m, na_m_next;
  logic signed [33:0] na_x, na_y, na_x_next, na_y_next;
  logic signed [33:0] nb_x, nb_y, nb_x_next, nb_y_next;

  always_comb begin
    int k;
    logic [32:0] m;
    m = s1_m;
    na_x_next = s1_x;
    na_y_next = s1_y;
    for (int j = 0; j < 3; j++) begin
      k = 32 >> j;
      if (m < (33'd1 << (33 - k))) begin
        m = m << k;
        na_x_next = na_x_next <<< k;
        na_y_next = na_y_next <<< k;
      end
    end
    na_m_next = m;
  end

  always_comb begin
    int k;
    logic [32:0] m;
    m = na_m;
    nb_x_next = na_x;
    nb_y_next = na_y;
    for (int j = 3; j < 6; j++) begin
      k = 32 >> j;
      if (m < (33'd1 << (33 - k))) begin
        m = m << k;
        nb_x_next = nb_x_next <<< k;
        nb_y_next = nb_y_next <<< k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_m <= na_m_next;
      na_x <= na_x_next;
      na_y <= na_y_next;
      nb_x <= nb_x_next;
      nb_y <= nb_y_next;
    end
  end

  // Stage 4: quarter-turn pre-rotation into the right half-plane.
  logic signed [VEC_W-1:0] vx [0:N];
  logic signed [VEC_W-1:0] vy [0:N];
  logic signed [ANG_W-1:0] vz [0:N];
  logic signed [VEC_W-1:0] px, py;

  assign px = VEC_W'(nb_x);
  assign py = VEC_W'(nb_y);

  always_ff @(posedge clk) begin
    if (en) begin
      if (nb_x < 0) begin
        if (nb_y >= 0) begin
          vx[0] <= py;
          vy[0] <= -px;
          vz[0] <= HALFPI_Q30;
        end else begin
          vx[0] <= -py;
          vy[0] <= px;
          vz[0] <= -HALFPI_Q30;
        end
      end else begin
        vx[0] <= px;
        vy[0] <= py;
        vz[0] <= '0;
      end
    end
  end

  // Vectoring CORDIC, one register stage per step.
  for (genvar gi = 0; gi < N; gi++) begin : g_vec
    localparam logic signed [ANG_W-1:0] A = atan_step(gi);
    always_ff @(posedge clk) begin
      if (en) begin
        if (vy[gi] >= 0) begin
          vx[gi+1] <= vx[gi] + (vy[gi] >>> gi);
          vy[gi+1] <= vy[gi] - (vx[gi] >>> gi);
          vz[gi+1] <= vz[gi] + A;
        end else begin
          vx[gi+1] <= vx[gi] - (vy[gi] >>> gi);
          vy[gi+1] <= vy[gi] + (vx[gi] >>> gi);
          vz[gi+1] <= vz[gi] - A;
        end
      end
    end
  end

  // Corner angles: +half angle for p1, -half angle for p2, the line angle for p3.
  logic signed [ANG_W-1:0] ang;
  logic signed [ANG_W-1:0] th_a [3];

  assign ang = sb[ST_VEC_END].zero ? '0 : vz[N];

  always_ff @(posedge clk) begin
    if (en) begin
      th_a[0] <= ang + HALF_ANGLE_Q30;
      th_a[1] <= ang - HALF_ANGLE_Q30;
      th_a[2] <= ang;
    end
  end

  // Fold into [-pi/2, pi/2]; the result is negated at the end of the rotation.
  logic signed [ROT_W-1:0] rx  [0:N][3];
  logic signed [ROT_W-1:0] ry  [0:N][3];
  logic signed [ANG_W-1:0] rth [0:N][3];
  logic [2:0]              rneg [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rx[0][k] <= INVGAIN_Q30;
        ry[0][k] <= '0;
        if (th_a[k] > HALFPI_Q30) begin
          rth[0][k]  <= th_a[k] - PI_Q30;
          rneg[0][k] <= 1'b1;
        end else if (th_a[k] < -HALFPI_Q30) begin
          rth[0][k]  <= th_a[k] + PI_Q30;
          rneg[0][k] <= 1'b1;
        end else begin
          rth[0][k]  <= th_a[k];
          rneg[0][k] <= 1'b0;
        end
      end
    end
  end

  // Three rotation CORDICs side by side, one register stage per step.
  for (genvar gi = 0; gi < N; gi++) begin : g_rot
    localparam logic signed [ANG_W-1:0] A = atan_step(gi);
    always_ff @(posedge clk) begin
      if (en) begin
        rneg[gi+1] <= rneg[gi];
        for (int k = 0; k < 3; k++) begin
          if (rth[gi][k] >= 0) begin
            rx[gi+1][k]  <= rx[gi][k] - (ry[gi][k] >>> gi);
            ry[gi+1][k]  <= ry[gi][k] + (rx[gi][k] >>> gi);
            rth[gi+1][k] <= rth[gi][k] - A;
          end else begin
            rx[gi+1][k]  <= rx[gi][k] + (ry[gi][k] >>> gi);
            ry[gi+1][k]  <= ry[gi][k] - (rx[gi][k] >>> gi);
            rth[gi+1][k] <= rth[gi][k] + A;
          end
        end
      end
    end
  end

  // Cosine and sine, scaled offsets, corner points.
  logic signed [ROT_W-1:0] cc [3];
  logic signed [ROT_W-1:0] ss [3];
  logic signed [65:0]      pr [6];
  logic signed [OFF_W-1:0] off [6];
  logic signed [OFF_W-1:0] off_next [6];
  logic signed [31:0]      pt [6];
  logic signed [31:0]      pt_next [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cc[k] <= rneg[N][k] ? -rx[N][k] : rx[N][k];
        ss[k] <= rneg[N][k] ? -ry[N][k] : ry[N][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pr[2*k]   <= cc[k] * $signed({1'b0, sb[ST_NEG].side});
        pr[2*k+1] <= ss[k] * $signed({1'b0, sb[ST_NEG].side});
      end
    end
  end

  // The back point uses twice the side, so one bit less of shift.
  always_comb begin
    logic signed [65:0] rnd;
    logic signed [65:0] sh;
    for (int q = 0; q < 6; q++) begin
      if (q < 4) begin
        rnd = pr[q] + (66'sd1 <<< 29);
        sh  = rnd >>> 30;
      end else begin
        rnd = pr[q] + (66'sd1 <<< 28);
        sh  = rnd >>> 29;
      end
      off_next[q] = sh[OFF_W-1:0];
    end
  end

  always_comb begin
    logic signed [37:0] d;
    logic signed [31:0] e;
    for (int q = 0; q < 6; q++) begin
      e = q[0] ? sb[ST_OFF].ey : sb[ST_OFF].ex;
      d = 38'(e) - 38'(off[q]);
      if (d[37:31] != {7{d[37]}}) begin
        pt_next[q] = d[37] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        pt_next[q] = d[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off <= off_next;
      pt  <= pt_next;
    end
  end

  // Sideband travels with the data.
  for (genvar gj = 2; gj < DEPTH; gj++) begin : g_sb
    always_ff @(posedge clk) begin
      if (en) begin
        sb[gj] <= sb[gj-1];
      end
    end
  end

  // Serializer: one cap held, one beat per output load.
  logic               busy;
  logic [2:0]         k_beat;
  logic [3:0]         q_style;
  logic signed [31:0] q_ex, q_ey;
  logic [30:0]        q_rad;
  logic signed [31:0] q_pt [6];
  logic [2:0]         b_cmd, b_sel, cls;
  logic               blast;
  logic signed [31:0] b_px, b_py;

  always_comb begin
    logic [2:0] g;
    logic [2:0] n;
    logic       closed;
    closed = !q_style[0];
    b_cmd  = CMD_STROKE;
    b_sel  = SEL_ZERO;
    priority if (q_style > STYLE_CLOSED_TRIANGLE) begin
      cls = CLS_ERROR;
      g   = 3'd1;
      n   = 3'd1;
    end else if (q_style <= STYLE_CLOSED_ROUND) begin
      cls = CLS_ROUND;
      g   = 3'd1;
      n   = 3'd1 + 3'(closed);
    end else if (q_style <= STYLE_CLOSED_ARROW) begin
      cls = CLS_ARROW;
      g   = 3'd3;
      n   = 3'd4 + 3'(closed);
    end else if (q_style <= STYLE_CLOSED_SQUARE) begin
      cls = CLS_SQUARE;
      g   = 3'd5;
      n   = 3'd6 + 3'(closed);
    end else begin
      cls = CLS_TRI;
      g   = 3'd4;
      n   = 3'd5 + 3'(closed);
    end
    if (k_beat < g) begin
      unique case (cls)
        CLS_ERROR: begin
          b_cmd = CMD_ERROR;
          b_sel = SEL_ZERO;
        end
        CLS_ROUND: begin
          b_cmd = CMD_CIRCLE;
          b_sel = SEL_END;
        end
        CLS_ARROW: begin
          b_cmd = (k_beat == 3'd0) ? CMD_MOVE : CMD_LINE;
          unique case (k_beat)
            3'd0:    b_sel = SEL_P1;
            3'd1:    b_sel = SEL_END;
            default: b_sel = SEL_P2;
          endcase
        end
        CLS_SQUARE: begin
          b_cmd = (k_beat == 3'd0) ? CMD_MOVE : CMD_LINE;
          unique case (k_beat)
            3'd1:    b_sel = SEL_P2;
            3'd2:    b_sel = SEL_P3;
            3'd3:    b_sel = SEL_P1;
            default: b_sel = SEL_END;
          endcase
        end
        default: begin
          b_cmd = (k_beat == 3'd0) ? CMD_MOVE : CMD_LINE;
          unique case (k_beat)
            3'd1:    b_sel = SEL_P1;
            3'd2:    b_sel = SEL_P2;
            default: b_sel = SEL_END;
          endcase
        end
      endcase
    end else if (k_beat == g && closed) begin
      b_cmd = CMD_FILL;
    end
    blast = (k_beat == n - 3'd1);
  end

  always_comb begin
    unique case (b_sel)
      SEL_END: begin
        b_px = q_ex;
        b_py = q_ey;
      end
      SEL_P1: begin
        b_px = q_pt[0];
        b_py = q_pt[1];
      end
      SEL_P2: begin
        b_px = q_pt[2];
        b_py = q_pt[3];
      end
      SEL_P3: begin
        b_px = q_pt[4];
        b_py = q_pt[5];
      end
      default: begin
        b_px = '0;
        b_py = '0;
      end
    endcase
  end

  assign ld       = !out_valid || !out_stall;
  assign take     = !busy || (ld && blast);
  assign en       = !vld[DEPTH-1] || take;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k_beat    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ld) begin
        out_valid <= busy;
        if (busy) begin
          k_beat <= k_beat + 3'd1;
          if (blast) begin
            busy <= 1'b0;
          end
        end
      end
      if (take && vld[DEPTH-1] && sb[ST_PNT].style != STYLE_NONE) begin
        busy   <= 1'b1;
        k_beat <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld && busy) begin
      command <= b_cmd;
      point_x <= b_px;
      point_y <= b_py;
      radius  <= (b_cmd == CMD_CIRCLE) ? q_rad : '0;
      last    <= blast;
    end
    if (take && vld[DEPTH-1]) begin
      q_style <= sb[ST_PNT].style;
      q_ex    <= sb[ST_PNT].ex;
      q_ey    <= sb[ST_PNT].ey;
      q_rad   <= sb[ST_PNT].rad;
      q_pt    <= pt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lecpg_chk.sv =====
// Port-level checker for the line end cap path generator and its bind.
`default_nettype none

module lecpg_chk (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [2:0]         command,
  input wire logic signed [31:0] point_x,
  input wire logic signed [31:0] point_y,
  input wire logic [30:0]        radius,
  input wire logic               last
);
  import lecpg_pkg::*;

  // A stalled result beat holds its command and point.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(command) && $stable(point_x)
      && $stable(point_y))
    else $error("result beat changed while stalled");

  // Only a circle carries a radius.
  a_radius: assert property (@(posedge clk) disable iff (rst)
    out_valid && command != CMD_CIRCLE |-> radius == '0)
    else $error("radius on a non-circle command");

  // Fill, stroke and error beats carry no point.
  a_no_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == CMD_FILL || command == CMD_STROKE || command == CMD_ERROR)
      |-> point_x == '0 && point_y == '0)
    else $error("point on a fill, stroke or error command");

  // Stroke and error beats close a cap; move and line beats never do.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((command == CMD_STROKE || command == CMD_ERROR) ? last
      : !(last && (command == CMD_MOVE || command == CMD_LINE))))
    else $error("wrong last flag");

endmodule

bind line_end_cap_path_generator_top lecpg_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .command   (command),
  .point_x   (point_x),
  .point_y   (point_y),
  .radius    (radius),
  .last      (last)
);

`default_nettype wire
